/* rtl/midi_nrpn_decoder_unit_defines.svh */
// Assertion macros shared by the NRPN decoder checker.
`ifndef MIDI_NRPN_DECODER_UNIT_DEFINES_SVH
`define MIDI_NRPN_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MNRPN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MNRPN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mnrpn_pkg.sv */
// Package: constants and types for the MIDI NRPN decoder.
`default_nettype none

package mnrpn_pkg;

  localparam int NUM_CHANNELS_DEF = 16;

  localparam int CH_W    = 4;
  localparam int BYTE7_W = 7;
  localparam int PARAM_W = 14;
  localparam int PHASE_W = 3;

  // Controller numbers
  localparam logic [BYTE7_W-1:0] CC_PARAM_HIGH = 7'd99;
  localparam logic [BYTE7_W-1:0] CC_PARAM_LOW  = 7'd98;
  localparam logic [BYTE7_W-1:0] CC_DATA_MSB   = 7'd6;
  localparam logic [BYTE7_W-1:0] CC_DATA_LSB   = 7'd38;
  localparam logic [BYTE7_W-1:0] DATA_BYTE_MAX = 7'd127;

  // Message kinds on the input
  localparam logic OP_CTRL  = 1'b0;
  localparam logic OP_PITCH = 1'b1;

  // Result kinds
  localparam logic KIND_NRPN  = 1'b0;
  localparam logic KIND_PLAIN = 1'b1;

  // Per-channel tracker phase
  localparam logic [PHASE_W-1:0] PH_PARAM_MSB = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PARAM_LSB = 3'd1;
  localparam logic [PHASE_W-1:0] PH_VALUE_MSB = 3'd2;
  localparam logic [PHASE_W-1:0] PH_VALUE_LSB = 3'd3;
  localparam logic [PHASE_W-1:0] PH_COMPLETE  = 3'd4;

  typedef struct packed {
    logic               kind;
    logic [CH_W-1:0]    channel;
    logic [PARAM_W-1:0] parameter_res;
    logic [BYTE7_W-1:0] value_high;
    logic [BYTE7_W-1:0] value_low;
    logic               low_seen;
  } mnrpn_result_t;

endpackage

`default_nettype wire

/* rtl/midi_nrpn_decoder_unit.sv */
// MIDI NRPN decoder: per-channel NRPN tracker with registered input and result.
//
//   channel   direction  handshake              payload
//   in_       input      in_valid / in_ready    op, channel, controller, data_value
//   out_      output     out_valid / out_ready  kind, channel, parameter_res,
//                                               value_high, value_low, low_seen
//
// A transaction passes through the input register and then the result register
// on its way to a result. Throughput is one transaction per cycle while the result is not stalled;
// the tracker update is a single read-modify-write of the addressed channel.
// rst_n is synchronous, active low, and clears every tracker entry at once.
// A stalled result holds the result register; the input register still drains
// an item that produces no result, so in_ready only drops when both are full.
`default_nettype none

module midi_nrpn_decoder_unit
  import mnrpn_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_op,
  input  wire logic [CH_W-1:0]    in_channel,
  input  wire logic [BYTE7_W-1:0] in_controller,
  input  wire logic [BYTE7_W-1:0] in_data_value,

  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_kind,
  output logic [CH_W-1:0]         out_channel,
  output logic [PARAM_W-1:0]      out_parameter_res,
  output logic [BYTE7_W-1:0]      out_value_high,
  output logic [BYTE7_W-1:0]      out_value_low,
  output logic                    out_low_seen
);

  // Bits needed to address one tracker entry.
  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic               s1_valid_r;
  logic               s1_op_r;
  logic [CH_W-1:0]    s1_ch_r;
  logic [BYTE7_W-1:0] s1_ctl_r;
  logic [BYTE7_W-1:0] s1_val_r;

  // ---------------------------------------------------------------------------
  // Per-channel tracker
  // ---------------------------------------------------------------------------
  // The stored value LSB is never read back: every NRPN result takes it
  // straight from the transaction that produces the result.
  logic [BYTE7_W-1:0] param_high_r [NUM_CHANNELS];
  logic [BYTE7_W-1:0] param_low_r  [NUM_CHANNELS];
  logic [BYTE7_W-1:0] val_high_r   [NUM_CHANNELS];
  logic               lsb_flag_r   [NUM_CHANNELS];
  logic [PHASE_W-1:0] phase_r      [NUM_CHANNELS];

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic          out_valid_r;
  mnrpn_result_t res_r;
  mnrpn_result_t res_nxt;

  logic [IDX_W-1:0]   idx;
  logic               ch_ok;
  logic [PHASE_W-1:0] cur_phase;
  logic               do_msb;
  logic               do_lsb;
  logic               do_phigh;
  logic               do_plow;
  logic               do_plain;
  logic               emit;
  logic               out_free;
  logic               s1_go;
  logic [BYTE7_W-1:0] fill_low;

  assign idx   = s1_ch_r[IDX_W-1:0];
  // Channels past the tracker depth get plain pass-through only.
  assign ch_ok = ({1'b0, s1_ch_r} < (CH_W+1)'(NUM_CHANNELS));

  assign cur_phase = ch_ok ? phase_r[idx] : PH_PARAM_MSB;

  // Decode the transaction against the channel's phase. Data entry only
  // counts when it arrives in sequence; otherwise it falls through.
  assign do_msb   = ch_ok && (s1_ctl_r == CC_DATA_MSB) && (cur_phase == PH_VALUE_MSB);
  assign do_lsb   = ch_ok && (s1_ctl_r == CC_DATA_LSB) && (cur_phase == PH_VALUE_LSB);
  assign do_phigh = ch_ok && (s1_ctl_r == CC_PARAM_HIGH);
  assign do_plow  = ch_ok && (s1_ctl_r == CC_PARAM_LOW);
  // Pitch wheel feeds the tracker but never passes through.
  assign do_plain = !(do_msb || do_lsb || do_phigh || do_plow) && (s1_op_r == OP_CTRL);

  assign emit = do_msb || do_lsb || do_plain;

  // Advance the input register when its item needs no result slot or one is free.
  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && (!emit || out_free);
  assign in_ready = !s1_valid_r || s1_go;

  // Value MSB fills the LSB with all zeros or all ones.
  assign fill_low = (s1_val_r == '0) ? '0 : DATA_BYTE_MAX;

  always_comb begin
    res_nxt = '0;
    if (do_plain) begin
      res_nxt.kind          = KIND_PLAIN;
      res_nxt.channel       = s1_ch_r;
      res_nxt.parameter_res = {{(PARAM_W-BYTE7_W){1'b0}}, s1_ctl_r};
      res_nxt.value_high    = s1_val_r;
      res_nxt.value_low     = '0;
      res_nxt.low_seen      = 1'b0;
    end else begin
      res_nxt.kind          = KIND_NRPN;
      res_nxt.channel       = s1_ch_r;
      res_nxt.parameter_res = {param_high_r[idx], param_low_r[idx]};
      res_nxt.value_high    = do_msb ? s1_val_r : val_high_r[idx];
      res_nxt.value_low     = do_msb ? fill_low : s1_val_r;
      res_nxt.low_seen      = do_lsb ? 1'b1 : lsb_flag_r[idx];
    end
  end

  // Input register: take a new transaction whenever the slot drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op_r  <= in_op;
      s1_ch_r  <= in_channel;
      s1_ctl_r <= in_controller;
      s1_val_r <= in_data_value;
    end
  end

  // Tracker update, once per transaction leaving the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        param_high_r[i] <= '0;
        param_low_r[i]  <= '0;
        val_high_r[i]   <= '0;
        lsb_flag_r[i]   <= 1'b0;
        phase_r[i]      <= PH_PARAM_MSB;
      end
    end else if (s1_go) begin
      if (do_msb) begin
        val_high_r[idx] <= s1_val_r;
        phase_r[idx]    <= PH_VALUE_LSB;
      end else if (do_lsb) begin
        lsb_flag_r[idx] <= 1'b1;
        phase_r[idx]    <= PH_COMPLETE;
      end else if (do_phigh) begin
        // Start a fresh parameter: drop any value in progress.
        lsb_flag_r[idx]   <= 1'b0;
        param_high_r[idx] <= s1_val_r;
        param_low_r[idx]  <= '0;
        val_high_r[idx]   <= '0;
        phase_r[idx]      <= PH_PARAM_LSB;
      end else if (do_plow) begin
        param_low_r[idx] <= s1_val_r;
        phase_r[idx]     <= PH_VALUE_MSB;
      end
    end
  end

  // Result register: load on an emitting transaction, clear once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = res_r.kind;
  assign out_channel       = res_r.channel;
  assign out_parameter_res = res_r.parameter_res;
  assign out_value_high    = res_r.value_high;
  assign out_value_low     = res_r.value_low;
  assign out_low_seen      = res_r.low_seen;

endmodule

`default_nettype wire

/* rtl/mnrpn_checker.sv */
// Port-level checker for the MIDI NRPN decoder, bound to the decoder unit.
`default_nettype none

`include "midi_nrpn_decoder_unit_defines.svh"

module mnrpn_checker
  import mnrpn_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               in_op,
  input wire logic [CH_W-1:0]    in_channel,
  input wire logic [BYTE7_W-1:0] in_controller,
  input wire logic [BYTE7_W-1:0] in_data_value,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_kind,
  input wire logic [CH_W-1:0]    out_channel,
  input wire logic [PARAM_W-1:0] out_parameter_res,
  input wire logic [BYTE7_W-1:0] out_value_high,
  input wire logic [BYTE7_W-1:0] out_value_low,
  input wire logic               out_low_seen
);

  logic          unused_in;
  mnrpn_result_t out_res;
  logic          out_stall;
  logic          plain_v;
  logic          plain_ok;
  logic          fill_v;

  assign unused_in = in_valid ^ in_ready ^ in_op ^ (^in_channel) ^ (^in_controller)
                     ^ (^in_data_value);

  assign out_res   = {out_kind, out_channel, out_parameter_res, out_value_high,
                      out_value_low, out_low_seen};
  assign out_stall = out_valid && !out_ready;
  assign plain_v   = out_valid && (out_kind == KIND_PLAIN);
  assign plain_ok  = (out_value_low == '0) && !out_low_seen
                     && (out_parameter_res[PARAM_W-1:BYTE7_W] == '0);
  assign fill_v    = out_valid && (out_kind == KIND_NRPN) && !out_low_seen;

  // A stalled result holds.
  `MNRPN_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_res), "result changed")

  // Pass-through results carry no LSB information.
  `MNRPN_ASSERT_NOW(a_plain_clean, plain_v, plain_ok, "plain result has NRPN fields set")

  // Without a received LSB the value LSB is the MSB fill.
  `MNRPN_ASSERT_NOW(a_msb_fill, fill_v && (out_value_high == '0), out_value_low == '0, "zero fill")

  `MNRPN_ASSERT_NOW(a_msb_fill_max, fill_v && (out_value_high != '0), out_value_low == DATA_BYTE_MAX, "max fill")

endmodule

bind midi_nrpn_decoder_unit mnrpn_checker u_mnrpn_checker (.*);

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the MIDI NRPN decoder unit.
module testbench
  import mnrpn_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One MIDI controller-type message as offered on the input channel.
  typedef struct {
    logic               op;
    logic [CH_W-1:0]    ch;
    logic [BYTE7_W-1:0] ctl;
    logic [BYTE7_W-1:0] val;
  } midi_msg_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_op = OP_CTRL;
  logic [CH_W-1:0]    in_channel = '0;
  logic [BYTE7_W-1:0] in_controller = '0;
  logic [BYTE7_W-1:0] in_data_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_kind;
  logic [CH_W-1:0]    out_channel;
  logic [PARAM_W-1:0] out_parameter_res;
  logic [BYTE7_W-1:0] out_value_high;
  logic [BYTE7_W-1:0] out_value_low;
  logic               out_low_seen;

  midi_nrpn_decoder_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_channel        (in_channel),
    .in_controller     (in_controller),
    .in_data_value     (in_data_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_channel       (out_channel),
    .out_parameter_res (out_parameter_res),
    .out_value_high    (out_value_high),
    .out_value_low     (out_value_low),
    .out_low_seen      (out_low_seen)
  );

  always #5 clk = ~clk;

  // Messages waiting for the driver, and decoder events still owed by the DUT.
  midi_msg_t     midi_tx_q[$];
  mnrpn_result_t pending_events[$];

  // Per-channel NRPN tracker mirror; cleared at time zero to match the DUT's store after reset.
  logic [BYTE7_W-1:0] trk_param_hi[NUM_CHANNELS_DEF];
  logic [BYTE7_W-1:0] trk_param_lo[NUM_CHANNELS_DEF];
  logic [BYTE7_W-1:0] trk_val_hi[NUM_CHANNELS_DEF];
  logic [BYTE7_W-1:0] trk_val_lo[NUM_CHANNELS_DEF];
  logic               trk_lsb_seen[NUM_CHANNELS_DEF];
  logic [PHASE_W-1:0] trk_phase[NUM_CHANNELS_DEF];

  // Pacing knobs, set by the sequencer between phases.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_len = 0;
  int hold_seq = 0;

  // Bookkeeping; each count but err_count is owned by a single process.
  int tx_offered = 0;     // driver: transactions put on the bus
  int in_taken_cnt = 0;   // input monitor: transactions accepted
  int hold_seen = 0;      // receiver
  int hold_left = 0;      // receiver
  int nrpn_seen = 0;
  int plain_seen = 0;
  int err_count = 0;

  initial begin
    for (int c = 0; c < NUM_CHANNELS_DEF; c++) begin
      trk_param_hi[c] = '0;
      trk_param_lo[c] = '0;
      trk_val_hi[c]   = '0;
      trk_val_lo[c]   = '0;
      trk_lsb_seen[c] = 1'b0;
      trk_phase[c]    = PH_PARAM_MSB;
    end
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_count++;
  endtask

  function automatic mnrpn_result_t nrpn_event(input logic [CH_W-1:0] ch);
    mnrpn_result_t ev;
    ev.kind          = KIND_NRPN;
    ev.channel       = ch;
    ev.parameter_res = {trk_param_hi[ch], trk_param_lo[ch]};
    ev.value_high    = trk_val_hi[ch];
    ev.value_low     = trk_val_lo[ch];
    ev.low_seen      = trk_lsb_seen[ch];
    return ev;
  endfunction

  // Advance the tracker mirror by one message; return 1 when the message
  // yields a decoder event, which is left in ev.
  function automatic bit nrpn_decode(input midi_msg_t m, output mnrpn_result_t ev);
    ev = '0;
    if (int'(m.ch) < NUM_CHANNELS_DEF) begin
      // Value MSB while a parameter is fully addressed: fill the LSB from the MSB.
      if (m.ctl == CC_DATA_MSB && trk_phase[m.ch] == PH_VALUE_MSB) begin
        trk_val_hi[m.ch] = m.val;
        trk_val_lo[m.ch] = (m.val == '0) ? '0 : DATA_BYTE_MAX;
        trk_phase[m.ch]  = PH_VALUE_LSB;
        ev = nrpn_event(m.ch);
        return 1'b1;
      end
      // Value LSB right after the MSB: complete the value.
      if (m.ctl == CC_DATA_LSB && trk_phase[m.ch] == PH_VALUE_LSB) begin
        trk_lsb_seen[m.ch] = 1'b1;
        trk_val_lo[m.ch]   = m.val;
        trk_phase[m.ch]    = PH_COMPLETE;
        ev = nrpn_event(m.ch);
        return 1'b1;
      end
      if (m.ctl == CC_PARAM_HIGH) begin
        trk_lsb_seen[m.ch] = 1'b0;
        trk_param_hi[m.ch] = m.val;
        trk_param_lo[m.ch] = '0;
        trk_val_hi[m.ch]   = '0;
        trk_val_lo[m.ch]   = '0;
        trk_phase[m.ch]    = PH_PARAM_LSB;
        return 1'b0;
      end
      if (m.ctl == CC_PARAM_LOW) begin
        trk_param_lo[m.ch] = m.val;
        trk_phase[m.ch]    = PH_VALUE_MSB;
        return 1'b0;
      end
    end
    // Everything else passes through, but only control changes report it.
    if (m.op == OP_PITCH) return 1'b0;
    ev.kind          = KIND_PLAIN;
    ev.channel       = m.ch;
    ev.parameter_res = PARAM_W'(m.ctl);
    ev.value_high    = m.val;
    return 1'b1;
  endfunction

  // Input monitor: on each accepted transaction, advance the mirror and
  // record the event it owes.
  always @(posedge clk) begin : in_monitor
    midi_msg_t     m;
    mnrpn_result_t ev;
    if (rst_n && in_valid && in_ready) begin
      m.op  = in_op;
      m.ch  = in_channel;
      m.ctl = in_controller;
      m.val = in_data_value;
      if (nrpn_decode(m, ev)) pending_events.push_back(ev);
      in_taken_cnt++;
    end
  end

  // Driver: present a new message at the falling edge only once the previous
  // one was taken; hold valid and payload steady otherwise.
  always @(negedge clk) begin : tx_drive
    midi_msg_t m;
    if (rst_n && in_taken_cnt == tx_offered) begin
      if (midi_tx_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        m = midi_tx_q.pop_front();
        in_op         <= m.op;
        in_channel    <= m.ch;
        in_controller <= m.ctl;
        in_data_value <= m.val;
        in_valid      <= 1'b1;
        tx_offered++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(negedge clk) begin : rx_drive
    if (rst_n) begin
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Output monitor: check every accepted event against the oldest one owed.
  always @(posedge clk) begin : out_monitor
    mnrpn_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        flag_mismatch($sformatf("unexpected event kind=%0b ch=%0d param=%0d",
                                out_kind, out_channel, out_parameter_res));
      end else begin
        want = pending_events.pop_front();
        if (out_kind !== want.kind)
          flag_mismatch($sformatf("kind got %0b want %0b", out_kind, want.kind));
        if (out_channel !== want.channel)
          flag_mismatch($sformatf("channel got %0d want %0d", out_channel, want.channel));
        if (out_parameter_res !== want.parameter_res)
          flag_mismatch($sformatf("parameter got %0d want %0d",
                                  out_parameter_res, want.parameter_res));
        if (out_value_high !== want.value_high)
          flag_mismatch($sformatf("value_high got %0d want %0d",
                                  out_value_high, want.value_high));
        if (out_value_low !== want.value_low)
          flag_mismatch($sformatf("value_low got %0d want %0d",
                                  out_value_low, want.value_low));
        if (out_low_seen !== want.low_seen)
          flag_mismatch($sformatf("low_seen got %0b want %0b", out_low_seen, want.low_seen));
        if (want.kind == KIND_NRPN) nrpn_seen++;
        else plain_seen++;
      end
    end
  end

  task automatic push_msg(input logic op, input int ch, input int ctl, input int val);
    midi_msg_t m;
    m.op  = op;
    m.ch  = CH_W'(ch);
    m.ctl = BYTE7_W'(ctl);
    m.val = BYTE7_W'(val);
    midi_tx_q.push_back(m);
  endtask

  // Pick a data byte, skewed toward zero so the MSB-zero fill shows up often.
  function automatic int rand_byte();
    return ($urandom_range(99) < 15) ? 0 : $urandom_range(127);
  endfunction

  // Mostly well-formed NRPN sequences with random content; the rest are
  // broken sequences and random noise.
  task automatic queue_random(input int n);
    int made;
    int ch;
    int len;
    int pick;
    logic op;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      ch   = $urandom_range(15);
      op   = ($urandom_range(9) == 0) ? OP_PITCH : OP_CTRL;
      if (pick < 65) begin
        push_msg(op, ch, CC_PARAM_HIGH, rand_byte());
        push_msg(op, ch, CC_PARAM_LOW, rand_byte());
        push_msg(op, ch, CC_DATA_MSB, rand_byte());
        made += 3;
        if ($urandom_range(9) < 7) begin
          push_msg(op, ch, CC_DATA_LSB, rand_byte());
          made++;
        end
        // Repeated data entry after the sequence moved on.
        if ($urandom_range(9) < 2) begin
          push_msg(1'($urandom_range(1)), ch,
                   $urandom_range(1) ? CC_DATA_MSB : CC_DATA_LSB, rand_byte());
          made++;
        end
      end else if (pick < 80) begin
        // Truncated or reordered sequence.
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(3))
            0: push_msg(op, ch, CC_PARAM_HIGH, rand_byte());
            1: push_msg(op, ch, CC_PARAM_LOW, rand_byte());
            2: push_msg(op, ch, CC_DATA_MSB, rand_byte());
            default: push_msg(op, ch, CC_DATA_LSB, rand_byte());
          endcase
        end
        made += len;
      end else begin
        push_msg(1'($urandom_range(1)), ch, $urandom_range(127), $urandom_range(127));
        made++;
      end
    end
  endtask

  // Hold the sequencer until every message is taken and every event has come.
  task automatic wait_drained();
    while (midi_tx_q.size() > 0 || in_taken_cnt != tx_offered || pending_events.size() > 0)
      @(posedge clk);
  endtask

  // Sequencer: reset, directed cases, then three pacing phases of random traffic.
  initial begin : sequencer
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    tx_idle_pct = 26;
    rx_idle_pct = 66;

    // Plain control changes at the byte extremes; a pitch wheel gives nothing.
    push_msg(OP_CTRL, 0, 0, 0);
    push_msg(OP_CTRL, 0, 127, 127);
    push_msg(OP_PITCH, 0, 5, 64);
    // Data entry out of sequence passes through as plain, but a pitch wheel gives nothing.
    push_msg(OP_CTRL, 1, CC_DATA_MSB, 9);
    push_msg(OP_CTRL, 1, CC_DATA_LSB, 10);
    push_msg(OP_PITCH, 1, CC_DATA_MSB, 11);
    // Full sequence at the top channel, MSB zero fills the LSB with zero.
    push_msg(OP_CTRL, 15, CC_PARAM_HIGH, 127);
    push_msg(OP_CTRL, 15, CC_PARAM_LOW, 127);
    push_msg(OP_CTRL, 15, CC_DATA_MSB, 0);
    push_msg(OP_CTRL, 15, CC_DATA_LSB, 127);
    // Repeated data entry after completion.
    push_msg(OP_CTRL, 15, CC_DATA_MSB, 3);
    push_msg(OP_CTRL, 15, CC_DATA_LSB, 4);
    // Nonzero MSB fills the LSB with 127; then restart mid-value.
    push_msg(OP_CTRL, 3, CC_PARAM_HIGH, 0);
    push_msg(OP_CTRL, 3, CC_PARAM_LOW, 0);
    push_msg(OP_CTRL, 3, CC_DATA_MSB, 127);
    push_msg(OP_CTRL, 3, CC_PARAM_HIGH, 10);
    push_msg(OP_CTRL, 3, CC_DATA_LSB, 5);
    // Pitch-wheel bytes still drive the tracker.
    push_msg(OP_PITCH, 5, CC_PARAM_HIGH, 64);
    push_msg(OP_PITCH, 5, CC_PARAM_LOW, 1);
    push_msg(OP_PITCH, 5, CC_DATA_MSB, 5);
    push_msg(OP_PITCH, 5, CC_DATA_MSB, 6);
    // Parameter LSB without a prior MSB.
    push_msg(OP_CTRL, 7, CC_PARAM_LOW, 3);
    push_msg(OP_CTRL, 7, CC_DATA_MSB, 1);
    push_msg(OP_CTRL, 7, CC_DATA_LSB, 0);
    wait_drained();

    queue_random(142);
    wait_drained();

    tx_idle_pct = 66;
    rx_idle_pct = 26;
    queue_random(142);
    wait_drained();

    // Stall the output for a long stretch while the sender keeps offering,
    // so the DUT fills and drops in_ready.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_len = 80;
    hold_seq++;
    queue_random(142);
    wait_drained();

    repeat (10) @(posedge clk);
    while (pending_events.size() > 0) begin
      void'(pending_events.pop_front());
      flag_mismatch("event never delivered");
    end

    $display("Run covered %0d messages: %0d NRPN value events, %0d plain control changes,",
             in_taken_cnt, nrpn_seen, plain_seen);
    $display("under mixed, reversed and no idling, with one long output stall.");
    if (err_count == 0) begin
      $display("PASS midi_nrpn_decoder_unit");
    end else begin
      $display("FAIL midi_nrpn_decoder_unit");
    end
    $finish;
  end

  // Watchdog: stops a hung run and reports failure.
  initial begin : watchdog
    #500_000;
    $display("FAIL midi_nrpn_decoder_unit");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/mnrpn_pkg.sv
rtl/midi_nrpn_decoder_unit.sv
rtl/mnrpn_checker.sv
dv/testbench.sv
